// ----- hw/rtl/sab_pkg.sv -----
// Shared types, codes and constants of the scaled alpha blitter.
// No dependencies; the controller, datapath, top level and checker import it.
`default_nettype none
package sab_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int CFG_W  = 7;   // size register width
  localparam int DIM_W  = 11;  // effective size width
  localparam int CRD_W  = 19;  // signed coordinate incl. scaled offset
  localparam int QACC_W = 17;  // scaled offset accumulator

  localparam logic [15:0] FULL_K  = 16'd65025;
  localparam logic [16:0] RECIP_K = 17'd66051;  // floor(2^32 / 65025)

  typedef enum logic [1:0] {
    CMD_WR_SRC = 2'd0,
    CMD_WR_DST = 2'd1,
    CMD_RD_DST = 2'd2,
    CMD_BLIT   = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_DST_W = 2'd2;
  localparam logic [1:0] REG_DST_H = 2'd3;

  typedef struct packed {
    logic load;
    logic disp;
    logic div_start;
    logic div_sel;
    logic rd;
    logic wr;
    logic adv;
    logic out_load;
  } sab_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic div_busy;
    logic pix_ok;
    logic last;
  } sab_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sab_if.sv -----
// Valid/ready channel interfaces for the blitter's item and result.
// No dependencies.
`default_nettype none
interface sab_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [8:0] x_a;
  logic signed [8:0] y_a;
  logic [7:0]        w_a;
  logic [7:0]        h_a;
  logic signed [8:0] x_b;
  logic signed [8:0] y_b;
  logic [7:0]        w_b;
  logic [7:0]        h_b;
  logic [7:0]        opacity;
  logic [31:0]       pixel_in;

  modport source (output valid, cmd, x_a, y_a, w_a, h_a, x_b, y_b, w_b, h_b,
                  opacity, pixel_in, input ready);
  modport sink (input valid, cmd, x_a, y_a, w_a, h_a, x_b, y_b, w_b, h_b,
                opacity, pixel_in, output ready);
endinterface

interface sab_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic [1:0]  status;

  modport source (output valid, pixel_out, status, input ready);
  modport sink (input valid, pixel_out, status, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sab_ctrl.sv -----
// Blitter controller: sequences commands, divider runs and the pixel loop.
// Depends on sab_pkg.
`default_nettype none
module sab_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire sab_pkg::sab_stat_t stat,
  output sab_pkg::sab_cmd_t       cmd
);
  import sab_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_DIVX, S_DIVY, S_CHK, S_MK, S_MS, S_MQ, S_WR, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.disp = 1'b1;
        if (stat.cmd == CMD_BLIT && !stat.empty) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVX;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIVX: begin
        if (!stat.div_busy) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_nxt     = S_DIVY;
        end
      end
      S_DIVY: begin
        if (!stat.div_busy) state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.pix_ok) begin
          cmd.rd    = 1'b1;
          state_nxt = S_MK;
        end else if (stat.last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      S_MK: state_nxt = S_MS;
      S_MS: state_nxt = S_MQ;
      S_MQ: state_nxt = S_WR;
      S_WR: begin
        cmd.wr = 1'b1;
        if (stat.last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- hw/rtl/sab_datapath.sv -----
// Blitter datapath: surfaces, size registers, scale divider, DDA and blend.
// Depends on sab_pkg.
`default_nettype none
module sab_datapath #(
  parameter int MAX_WIDTH  = sab_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sab_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [sab_pkg::CFG_W-1:0] cfg_data,
  input  wire logic [1:0]                i_cmd,
  input  wire logic signed [8:0]         i_xa,
  input  wire logic signed [8:0]         i_ya,
  input  wire logic [7:0]                i_wa,
  input  wire logic [7:0]                i_ha,
  input  wire logic signed [8:0]         i_xb,
  input  wire logic signed [8:0]         i_yb,
  input  wire logic [7:0]                i_wb,
  input  wire logic [7:0]                i_hb,
  input  wire logic [7:0]                i_op,
  input  wire logic [31:0]               i_pix,
  input  wire sab_pkg::sab_cmd_t         cmd,
  output sab_pkg::sab_stat_t             stat,
  output logic [31:0]                    o_pixel,
  output logic [1:0]                     o_status
);
  import sab_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [DIM_W-1:0] eff(input logic [CFG_W-1:0] v, input int mx);
    logic [DIM_W-1:0] e;
    e = DIM_W'(v);
    if (e == '0) e = DIM_W'(1);
    if (e > DIM_W'(mx)) e = DIM_W'(mx);
    return e;
  endfunction

  function automatic logic in_rect(input logic signed [CRD_W-1:0] x,
                                   input logic signed [CRD_W-1:0] y,
                                   input logic [DIM_W-1:0] w,
                                   input logic [DIM_W-1:0] h);
    logic signed [CRD_W-1:0] ws, hs;
    ws = $signed({{(CRD_W-DIM_W){1'b0}}, w});
    hs = $signed({{(CRD_W-DIM_W){1'b0}}, h});
    return (x >= 0) && (y >= 0) && (x < ws) && (y < hs);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic signed [CRD_W-1:0] x,
                                                input logic signed [CRD_W-1:0] y);
    return ADDR_W'(ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x));
  endfunction

  // size registers
  logic [CFG_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= CFG_W'(1);
      src_h_r <= CFG_W'(1);
      dst_w_r <= CFG_W'(1);
      dst_h_r <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_W: src_w_r <= cfg_data;
        REG_SRC_H: src_h_r <= cfg_data;
        REG_DST_W: dst_w_r <= cfg_data;
        REG_DST_H: dst_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] sw, sh, dw, dh;
  assign sw = eff(src_w_r, MAX_WIDTH);
  assign sh = eff(src_h_r, MAX_HEIGHT);
  assign dw = eff(dst_w_r, MAX_WIDTH);
  assign dh = eff(dst_h_r, MAX_HEIGHT);

  // latched item
  cmd_t              cmd_r;
  logic signed [8:0] xa_r, ya_r, xb_r, yb_r;
  logic [7:0]        wa_r, ha_r, wb_r, hb_r, op_r;
  logic [31:0]       pix_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= cmd_t'(i_cmd);
      xa_r  <= i_xa;
      ya_r  <= i_ya;
      wa_r  <= i_wa;
      ha_r  <= i_ha;
      xb_r  <= i_xb;
      yb_r  <= i_yb;
      wb_r  <= i_wb;
      hb_r  <= i_hb;
      op_r  <= i_op;
      pix_r <= i_pix;
    end
  end

  logic signed [CRD_W-1:0] xa_s, ya_s;
  logic                    in_src, in_dst, empty;
  assign xa_s   = CRD_W'(xa_r);
  assign ya_s   = CRD_W'(ya_r);
  assign in_src = in_rect(xa_s, ya_s, sw, sh);
  assign in_dst = in_rect(xa_s, ya_s, dw, dh);
  assign empty  = (wa_r == '0) || (ha_r == '0) || (wb_r == '0) || (hb_r == '0);

  // serial divider for the scale steps w_b/w_a and h_b/h_a
  logic [7:0] div_q_r, div_rem_r, qsx_r, rsx_r, qsy_r, rsy_r;
  logic [3:0] div_cnt_r;
  logic       div_sel_r;
  logic [7:0] divisor, rem_n, q_n;
  logic [8:0] div_t;
  logic       div_ge;
  assign divisor = div_sel_r ? ha_r : wa_r;
  assign div_t   = {div_rem_r, div_q_r[7]};
  assign div_ge  = div_t >= {1'b0, divisor};
  assign rem_n   = div_ge ? 8'(div_t - {1'b0, divisor}) : div_t[7:0];
  assign q_n     = {div_q_r[6:0], div_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_cnt_r <= 4'd8;
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_sel_r <= cmd.div_sel;
      div_q_r   <= cmd.div_sel ? hb_r : wb_r;
      div_rem_r <= '0;
    end else if (div_cnt_r != '0) begin
      div_q_r   <= q_n;
      div_rem_r <= rem_n;
      if (div_cnt_r == 4'd1) begin
        if (div_sel_r) begin
          qsy_r <= q_n;
          rsy_r <= rem_n;
        end else begin
          qsx_r <= q_n;
          rsx_r <= rem_n;
        end
      end
    end
  end

  // pixel walk with incremental floor(p*w_b/w_a)
  logic [7:0]        px_r, py_r, rx_r, ry_r;
  logic [QACC_W-1:0] qx_r, qy_r;
  logic [8:0]        nrx, nry;
  logic              row_end;
  assign nrx     = {1'b0, rx_r} + {1'b0, rsx_r};
  assign nry     = {1'b0, ry_r} + {1'b0, rsy_r};
  assign row_end = px_r == wa_r - 8'd1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= '0;
      py_r <= '0;
      rx_r <= '0;
      ry_r <= '0;
      qx_r <= '0;
      qy_r <= '0;
    end else if (cmd.adv) begin
      if (row_end) begin
        px_r <= '0;
        rx_r <= '0;
        qx_r <= '0;
        py_r <= py_r + 8'd1;
        if (nry >= {1'b0, ha_r}) begin
          ry_r <= 8'(nry - {1'b0, ha_r});
          qy_r <= qy_r + QACC_W'(qsy_r) + QACC_W'(1);
        end else begin
          ry_r <= nry[7:0];
          qy_r <= qy_r + QACC_W'(qsy_r);
        end
      end else begin
        px_r <= px_r + 8'd1;
        if (nrx >= {1'b0, wa_r}) begin
          rx_r <= 8'(nrx - {1'b0, wa_r});
          qx_r <= qx_r + QACC_W'(qsx_r) + QACC_W'(1);
        end else begin
          rx_r <= nrx[7:0];
          qx_r <= qx_r + QACC_W'(qsx_r);
        end
      end
    end
  end

  logic signed [CRD_W-1:0] dx, dy, sx, sy;
  assign dx = xa_s + $signed({{(CRD_W-8){1'b0}}, px_r});
  assign dy = ya_s + $signed({{(CRD_W-8){1'b0}}, py_r});
  assign sx = CRD_W'(xb_r) + $signed({{(CRD_W-QACC_W){1'b0}}, qx_r});
  assign sy = CRD_W'(yb_r) + $signed({{(CRD_W-QACC_W){1'b0}}, qy_r});

  // surfaces
  logic [31:0]       src_mem [DEPTH];
  logic [31:0]       dst_mem [DEPTH];
  logic [31:0]       src_q_r, dst_q_r, blended;
  logic [ADDR_W-1:0] pt_addr, d_addr, s_addr;
  logic              src_we, dst_we, dst_re;
  assign pt_addr = addr_of(xa_s, ya_s);
  assign d_addr  = addr_of(dx, dy);
  assign s_addr  = addr_of(sx, sy);
  assign src_we  = cmd.disp && (cmd_r == CMD_WR_SRC) && in_src;
  assign dst_we  = cmd.wr || (cmd.disp && (cmd_r == CMD_WR_DST) && in_dst);
  assign dst_re  = cmd.rd || (cmd.disp && (cmd_r == CMD_RD_DST));

  always_ff @(posedge clk) begin
    if (src_we) src_mem[cmd.rd ? s_addr : pt_addr] <= pix_r;
    if (cmd.rd) src_q_r <= src_mem[s_addr];
  end

  always_ff @(posedge clk) begin
    if (dst_we) dst_mem[cmd.wr ? d_addr : pt_addr] <= cmd.wr ? blended : pix_r;
    if (dst_re) dst_q_r <= dst_mem[cmd.rd ? d_addr : pt_addr];
  end

  // blend: k, weighted sums, reciprocal estimate, then one correction
  logic [15:0] k_r, inv;
  logic [23:0] sum_r [4];
  logic [7:0]  q0_r [4];
  assign inv = FULL_K - k_r;

  always_ff @(posedge clk) begin
    k_r <= 16'(src_q_r[31:24]) * 16'(op_r);
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    logic [7:0]  sc, dc;
    logic [40:0] prod;
    logic [23:0] rem;
    assign sc   = (c < 3) ? src_q_r[8*c +: 8] : 8'd255;
    assign dc   = dst_q_r[8*c +: 8];
    assign prod = 41'(sum_r[c]) * 41'(RECIP_K);
    assign rem  = sum_r[c] - 24'(q0_r[c]) * 24'(FULL_K);
    always_ff @(posedge clk) begin
      sum_r[c] <= 24'(sc) * 24'(k_r) + 24'(dc) * 24'(inv);
      q0_r[c]  <= prod[39:32];
    end
    assign blended[8*c +: 8] = q0_r[c] + 8'(rem >= 24'(FULL_K));
  end

  // result
  logic [1:0] stat_r;
  logic       rd_ok_r;
  always_ff @(posedge clk) begin
    if (cmd.disp) begin
      rd_ok_r <= (cmd_r == CMD_RD_DST) && in_dst;
      if (cmd_r == CMD_BLIT) stat_r <= empty ? ST_EMPTY : ST_DONE;
      else if (cmd_r == CMD_WR_SRC) stat_r <= in_src ? ST_DONE : ST_OUTSIDE;
      else stat_r <= in_dst ? ST_DONE : ST_OUTSIDE;
    end
    if (cmd.out_load) begin
      o_pixel  <= rd_ok_r ? dst_q_r : '0;
      o_status <= stat_r;
    end
  end

  assign stat.cmd      = cmd_r;
  assign stat.empty    = empty;
  assign stat.div_busy = div_cnt_r != '0;
  assign stat.pix_ok   = in_rect(dx, dy, dw, dh) && in_rect(sx, sy, sw, sh);
  assign stat.last     = row_end && (py_r == ha_r - 8'd1);

endmodule
`default_nettype wire

// ----- hw/rtl/scaled_alpha_blitter_unit.sv -----
// Top level of the scaled alpha blitter: controller plus datapath.
// Depends on sab_pkg, sab_if, sab_ctrl and sab_datapath.
//
//   channel  dir  handshake        carries
//   in_ch    in   valid/ready      cmd, rectangles, opacity, pixel_in
//   out_ch   out  valid/ready      pixel_out, status
//   cfg_*    in   cfg_we only      cfg_index, cfg_data (size registers)
//
// Pixel writes and reads pass through the dispatch and finish states to the result register.
// A blit runs both scale divisions, then checks each destination position;
// a drawn pixel goes through read, alpha product, sums, reciprocal, correct+write.
// One item at a time; the next is taken while the result waits in out_ch.
// Synchronous active-low reset; surfaces hold no reset and need no clearing.
`default_nettype none
module scaled_alpha_blitter_unit #(
  parameter int MAX_WIDTH  = sab_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sab_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  sab_in_if.sink                         in_ch,
  sab_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [sab_pkg::CFG_W-1:0] cfg_data
);
  import sab_pkg::*;

  sab_cmd_t  cmd;
  sab_stat_t stat;

  sab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sab_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .i_cmd     (in_ch.cmd),
    .i_xa      (in_ch.x_a),
    .i_ya      (in_ch.y_a),
    .i_wa      (in_ch.w_a),
    .i_ha      (in_ch.h_a),
    .i_xb      (in_ch.x_b),
    .i_yb      (in_ch.y_b),
    .i_wb      (in_ch.w_b),
    .i_hb      (in_ch.h_b),
    .i_op      (in_ch.opacity),
    .i_pix     (in_ch.pixel_in),
    .cmd       (cmd),
    .stat      (stat),
    .o_pixel   (out_ch.pixel_out),
    .o_status  (out_ch.status)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/sab_checker.sv -----
// Port-level checks for the scaled alpha blitter, bound to the top level.
// Depends on sab_pkg and scaled_alpha_blitter_unit.
`default_nettype none
module sab_port_checks (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] pixel_out,
  input wire logic [1:0]  status
);
  import sab_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(status))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status == ST_DONE || status == ST_EMPTY || status == ST_OUTSIDE)
    else $error("bad status code");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind scaled_alpha_blitter_unit sab_port_checks u_sab_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pixel_out (out_ch.pixel_out),
  .status    (out_ch.status)
);
`default_nettype wire
